// ===== rtl/ttcg_pkg.sv =====
// Shared widths, angle constants and the arctangent table of the tunnel
// texture coordinate generator. No dependencies.
package ttcg_pkg;

    // Register indexes of the configuration port
    localparam logic [7:0] REG_SCREEN_WIDTH  = 8'd0;
    localparam logic [7:0] REG_SCREEN_HEIGHT = 8'd1;
    localparam logic [7:0] REG_SCROLL_U      = 8'd2;
    localparam logic [7:0] REG_SCROLL_V      = 8'd3;

    // Screen size limits; the datapath widths below are sized for them
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int DEF_CORDIC_STAGES = 16;

    localparam int CFG_W   = 11;  // widest register
    localparam int PIX_W   = 10;  // pixel coordinate
    localparam int CEN_W   = 11;  // signed centered coordinate
    localparam int FRAC_W  = 16;  // fraction bits of the vector
    localparam int XW      = 30;  // signed vector component
    localparam int ZW      = 27;  // signed angle accumulator
    localparam int SQ_W    = 22;  // one square
    localparam int S_W     = 23;  // sum of squares
    localparam int LIM_W   = 38;  // 65536 * h * h
    localparam int PW      = 41;  // running v*v*s
    localparam int QW      = 32;  // running v*s
    localparam int VW      = 9;   // depth code 0..256
    localparam int ATAN_W  = 23;
    localparam int TABLE_LEN = 24;

    localparam logic signed [ZW-1:0] ANG_PI   = ZW'(1 << 24);
    localparam logic signed [ZW-1:0] ANG_HALF = ZW'(1 << 23);

    // Arctangent of 2^-k in units where pi is 2^24
    function automatic logic [ATAN_W-1:0] atan_lut(input int k);
        logic [ATAN_W-1:0] r;
        case (k)
            0:  r = 23'd4194304;
            1:  r = 23'd2476042;
            2:  r = 23'd1308273;
            3:  r = 23'd664100;
            4:  r = 23'd333339;
            5:  r = 23'd166832;
            6:  r = 23'd83436;
            7:  r = 23'd41721;
            8:  r = 23'd20861;
            9:  r = 23'd10430;
            10: r = 23'd5215;
            11: r = 23'd2608;
            12: r = 23'd1304;
            13: r = 23'd652;
            14: r = 23'd326;
            15: r = 23'd163;
            16: r = 23'd81;
            17: r = 23'd41;
            18: r = 23'd20;
            19: r = 23'd10;
            20: r = 23'd5;
            21: r = 23'd3;
            22: r = 23'd1;
            23: r = 23'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ttcg_front.sv =====
// Front end: centers the pixel, squares the offsets, pre-rotates the vector
// into the right half plane and forms the depth bound. Uses ttcg_pkg.
module ttcg_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_vld,
    input  logic [ttcg_pkg::PIX_W-1:0]        px,
    input  logic [ttcg_pkg::PIX_W-1:0]        py,
    input  logic [ttcg_pkg::CFG_W-1:0]        width,
    input  logic [ttcg_pkg::CFG_W-1:0]        height,
    output logic                              out_vld,
    output logic signed [ttcg_pkg::XW-1:0]    x,
    output logic signed [ttcg_pkg::XW-1:0]    y,
    output logic signed [ttcg_pkg::ZW-1:0]    z,
    output logic [ttcg_pkg::S_W-1:0]          s,
    output logic [ttcg_pkg::LIM_W-1:0]        lim
);
    import ttcg_pkg::*;

    // Stage 1: centered offsets
    logic                    v1_reg, v1_next;
    logic signed [CEN_W-1:0] i_reg, i_next;
    logic signed [CEN_W-1:0] y1_reg, y1_next;
    logic [CFG_W-1:0]        h_reg, h_next;

    // Stage 2: squares and pre-rotated vector
    logic                    v2_reg, v2_next;
    logic [SQ_W-1:0]         ii_reg, ii_next;
    logic [SQ_W-1:0]         jj_reg, jj_next;
    logic [SQ_W-1:0]         hh_reg, hh_next;
    logic signed [CEN_W-1:0] x2_reg, x2_next;
    logic signed [CEN_W-1:0] y2_reg, y2_next;
    logic signed [ZW-1:0]    z2_reg, z2_next;

    // Stage 3: scaled vector, sum and bound
    logic                    v3_reg, v3_next;
    logic signed [XW-1:0]    x3_reg, x3_next;
    logic signed [XW-1:0]    y3_reg, y3_next;
    logic signed [ZW-1:0]    z3_reg, z3_next;
    logic [S_W-1:0]          s3_reg, s3_next;
    logic [LIM_W-1:0]        lim3_reg, lim3_next;

    logic signed [2*CEN_W-1:0] isq, jsq;
    logic signed [CEN_W-1:0]   j1;
    logic signed [CEN_W-1:0]   xa, ya;
    logic signed [ZW-1:0]      za;

    // Center the pixel; y axis points up
    always_comb
    begin
        v1_next = in_vld;
        i_next  = $signed({1'b0, px}) - $signed({1'b0, width[CFG_W-1:1]});
        y1_next = $signed({1'b0, height[CFG_W-1:1]}) - $signed({1'b0, py});
        h_next  = height;
    end

    // Square offsets, move the vector into the right half plane
    always_comb
    begin
        j1      = -y1_reg;
        isq     = i_reg * i_reg;
        jsq     = j1 * j1;
        v2_next = v1_reg;
        ii_next = SQ_W'(isq);
        jj_next = SQ_W'(jsq);
        hh_next = SQ_W'(h_reg) * SQ_W'(h_reg);
        xa = i_reg;
        ya = y1_reg;
        za = '0;
        if (i_reg[CEN_W-1])
        begin
            xa = -i_reg;
            ya = -y1_reg;
            za = (ya[CEN_W-1] || (ya == '0)) ? ANG_PI : -ANG_PI;
        end
        if ((xa == '0) && (ya != '0))
        begin
            if (!ya[CEN_W-1])
            begin
                xa = ya;
                za = za + ANG_HALF;
            end
            else
            begin
                xa = -ya;
                za = za - ANG_HALF;
            end
            ya = '0;
        end
        x2_next = xa;
        y2_next = ya;
        z2_next = za;
    end

    // Scale the vector, sum squares, form the depth bound
    always_comb
    begin
        v3_next   = v2_reg;
        x3_next   = $signed({{(XW-CEN_W-FRAC_W){x2_reg[CEN_W-1]}}, x2_reg, {FRAC_W{1'b0}}});
        y3_next   = $signed({{(XW-CEN_W-FRAC_W){y2_reg[CEN_W-1]}}, y2_reg, {FRAC_W{1'b0}}});
        z3_next   = z2_reg;
        s3_next   = S_W'(ii_reg) + S_W'(jj_reg) + S_W'(hh_reg);
        lim3_next = {hh_reg, {FRAC_W{1'b0}}};
    end

    // Hold valid bits in reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_reg    <= i_next;
            y1_reg   <= y1_next;
            h_reg    <= h_next;
            ii_reg   <= ii_next;
            jj_reg   <= jj_next;
            hh_reg   <= hh_next;
            x2_reg   <= x2_next;
            y2_reg   <= y2_next;
            z2_reg   <= z2_next;
            x3_reg   <= x3_next;
            y3_reg   <= y3_next;
            z3_reg   <= z3_next;
            s3_reg   <= s3_next;
            lim3_reg <= lim3_next;
        end
    end

    assign out_vld = v3_reg;
    assign x       = x3_reg;
    assign y       = y3_reg;
    assign z       = z3_reg;
    assign s       = s3_reg;
    assign lim     = lim3_reg;

endmodule

// ===== rtl/ttcg_cell.sv =====
// One cell of the chain: a vectoring CORDIC iteration and, in the first
// nine cells, one bit of the depth code search. Uses ttcg_pkg.
module ttcg_cell #(
    parameter int IDX = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_vld,
    input  logic signed [ttcg_pkg::XW-1:0]  x_in,
    input  logic signed [ttcg_pkg::XW-1:0]  y_in,
    input  logic signed [ttcg_pkg::ZW-1:0]  z_in,
    input  logic [ttcg_pkg::S_W-1:0]        s_in,
    input  logic [ttcg_pkg::LIM_W-1:0]      lim_in,
    input  logic [ttcg_pkg::PW-1:0]         p_in,
    input  logic [ttcg_pkg::QW-1:0]         q_in,
    input  logic [ttcg_pkg::VW-1:0]         v_in,
    output logic                            out_vld,
    output logic signed [ttcg_pkg::XW-1:0]  x_out,
    output logic signed [ttcg_pkg::XW-1:0]  y_out,
    output logic signed [ttcg_pkg::ZW-1:0]  z_out,
    output logic [ttcg_pkg::S_W-1:0]        s_out,
    output logic [ttcg_pkg::LIM_W-1:0]      lim_out,
    output logic [ttcg_pkg::PW-1:0]         p_out,
    output logic [ttcg_pkg::QW-1:0]         q_out,
    output logic [ttcg_pkg::VW-1:0]         v_out
);
    import ttcg_pkg::*;

    localparam int BIT = VW - 1 - IDX;  // depth bit decided here
    localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(atan_lut(IDX)));

    logic                 vld_reg, vld_next;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [S_W-1:0]       s_reg, s_next;
    logic [LIM_W-1:0]     lim_reg, lim_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [VW-1:0]        v_reg, v_next;

    logic signed [XW-1:0] xs, ys;

    // Rotate toward the x axis; a zero y leaves the vector alone
    always_comb
    begin
        xs       = x_in >>> IDX;
        ys       = y_in >>> IDX;
        vld_next = in_vld;
        x_next   = x_in;
        y_next   = y_in;
        z_next   = z_in;
        s_next   = s_in;
        lim_next = lim_in;
        if (!y_in[XW-1] && (y_in != '0))
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
        else if (y_in[XW-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
    end

    // Try one depth bit: (v+b)^2*s = v^2*s + 2*b*v*s + b^2*s
    generate
        if (BIT >= 0)
        begin : g_depth
            logic [PW-1:0] trial;
            logic          take;
            always_comb
            begin
                trial = p_in + (PW'(q_in) << (BIT + 1)) + (PW'(s_in) << (2 * BIT));
                take  = (trial <= PW'(lim_in)) && ((BIT == VW - 1) || !v_in[VW-1]);
                p_next = p_in;
                q_next = q_in;
                v_next = v_in;
                if (take)
                begin
                    p_next = trial;
                    q_next = q_in + (QW'(s_in) << BIT);
                    v_next = v_in | (VW'(1) << BIT);
                end
            end
        end
        else
        begin : g_pass
            always_comb
            begin
                p_next = p_in;
                q_next = q_in;
                v_next = v_in;
            end
        end
    endgenerate

    // Hold valid in reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            s_reg   <= s_next;
            lim_reg <= lim_next;
            p_reg   <= p_next;
            q_reg   <= q_next;
            v_reg   <= v_next;
        end
    end

    assign out_vld = vld_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign s_out   = s_reg;
    assign lim_out = lim_reg;
    assign p_out   = p_reg;
    assign q_out   = q_reg;
    assign v_out   = v_reg;

endmodule

// ===== rtl/tunnel_texture_coordinate_generator.sv =====
// Pipeline: front stages, then CORDIC_STAGES cells (at most 24), then the output register.
// Throughput: one pixel per cycle; the whole chain advances together and
// halts only while a finished result is held by out_stall.
// Reset: asynchronous, active low; clears all valid bits and loads the
// registers with width 640, height 480 and zero scroll. Uses ttcg_pkg.
module tunnel_texture_coordinate_generator #(
    parameter int CORDIC_STAGES = ttcg_pkg::DEF_CORDIC_STAGES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [7:0]                    cfg_index,
    input  logic [ttcg_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ttcg_pkg::PIX_W-1:0]    pixel_x,
    input  logic [ttcg_pkg::PIX_W-1:0]    pixel_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    tex_u,
    output logic [7:0]                    tex_v
);
    import ttcg_pkg::*;

    localparam int NCELL = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [7:0]       scroll_u_reg, scroll_v_reg;

    logic adv;

    logic                 c_vld [0:NCELL];
    logic signed [XW-1:0] c_x   [0:NCELL];
    logic signed [XW-1:0] c_y   [0:NCELL];
    logic signed [ZW-1:0] c_z   [0:NCELL];
    logic [S_W-1:0]       c_s   [0:NCELL];
    logic [LIM_W-1:0]     c_lim [0:NCELL];
    logic [PW-1:0]        c_p   [0:NCELL];
    logic [QW-1:0]        c_q   [0:NCELL];
    logic [VW-1:0]        c_v   [0:NCELL];

    logic       out_valid_reg, out_valid_next;
    logic [7:0] tex_u_reg, tex_u_next;
    logic [7:0] tex_v_reg, tex_v_next;
    logic signed [ZW-1:0] zf, zq;

    // Configuration writes; oversize sizes saturate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= CFG_W'(640);
            height_reg   <= CFG_W'(480);
            scroll_u_reg <= '0;
            scroll_v_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:
                    width_reg <= (int'(cfg_data) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : cfg_data;
                REG_SCREEN_HEIGHT:
                    height_reg <= (int'(cfg_data) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : cfg_data;
                REG_SCROLL_U:
                    scroll_u_reg <= cfg_data[7:0];
                REG_SCROLL_V:
                    scroll_v_reg <= cfg_data[7:0];
                default:
                    ;
            endcase
        end
    end

    // Advance the chain unless a result waits on a stalled output
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    ttcg_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (in_valid),
        .px      (pixel_x),
        .py      (pixel_y),
        .width   (width_reg),
        .height  (height_reg),
        .out_vld (c_vld[0]),
        .x       (c_x[0]),
        .y       (c_y[0]),
        .z       (c_z[0]),
        .s       (c_s[0]),
        .lim     (c_lim[0])
    );

    assign c_p[0] = '0;
    assign c_q[0] = '0;
    assign c_v[0] = '0;

    // Row of cells
    generate
        for (genvar k = 0; k < NCELL; k++)
        begin : g_cell
            ttcg_cell #(.IDX(k)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .adv     (adv),
                .in_vld  (c_vld[k]),
                .x_in    (c_x[k]),
                .y_in    (c_y[k]),
                .z_in    (c_z[k]),
                .s_in    (c_s[k]),
                .lim_in  (c_lim[k]),
                .p_in    (c_p[k]),
                .q_in    (c_q[k]),
                .v_in    (c_v[k]),
                .out_vld (c_vld[k+1]),
                .x_out   (c_x[k+1]),
                .y_out   (c_y[k+1]),
                .z_out   (c_z[k+1]),
                .s_out   (c_s[k+1]),
                .lim_out (c_lim[k+1]),
                .p_out   (c_p[k+1]),
                .q_out   (c_q[k+1]),
                .v_out   (c_v[k+1])
            );
        end
    endgenerate

    // Truncate the angle toward zero, add scroll offsets
    always_comb
    begin
        zf = c_z[NCELL];
        zq = zf[ZW-1] ? -((-zf) >>> FRAC_W) : (zf >>> FRAC_W);
        out_valid_next = c_vld[NCELL];
        tex_u_next     = zq[7:0] + scroll_u_reg;
        tex_v_next     = c_v[NCELL][7:0] + scroll_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tex_u_reg <= tex_u_next;
            tex_v_reg <= tex_v_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;

`ifndef ASSERT_OFF
    a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled without a held result");

    a_depth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (c_vld[NCELL] && c_v[NCELL][VW-1]) |-> (c_v[NCELL][VW-2:0] == '0))
        else $error("depth code above 256");

    a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(tex_u) && $stable(tex_v)))
        else $error("held result changed");

    a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(c_v[NCELL]) && $stable(c_z[NCELL]))
        else $error("chain moved during stall");
`endif

endmodule

// ===== tb/tunnel_texture_coordinate_checker.sv =====
// Checker for the tunnel texture coordinate generator: watches the config
// port and both channels, predicts texture coordinates and compares them.
// Depends on ttcg_pkg for register indexes and widths.
module tunnel_texture_coordinate_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [7:0]                  cfg_index,
    input  logic [ttcg_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [ttcg_pkg::PIX_W-1:0]  pixel_x,
    input  logic [ttcg_pkg::PIX_W-1:0]  pixel_y,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [7:0]                  tex_u,
    input  logic [7:0]                  tex_v,
    output int                          fail_count,
    output int                          pending_count,
    output int                          result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ttcg_pkg::*;

    localparam int STAGES = 16;

    typedef struct packed {
        logic [7:0] u;
        logic [7:0] v;
    } coord_t;

    coord_t coord_queue[$];
    longint width_reg, height_reg;
    logic [7:0] scroll_u_reg, scroll_v_reg;

    function automatic longint floor_shift(longint a, int k);
        if (a >= 0)
            return a >>> k;
        return -1 - ((-1 - a) >>> k);
    endfunction

    function automatic logic [7:0] tunnel_angle(longint x, longint y);
        longint z, xs, ys, q;
        z = 0;
        if (x == 0 && y == 0)
            return 8'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = (y <= 0) ? (64'sd1 << 24) : -(64'sd1 << 24);
        end
        if (x == 0)
        begin
            if (y > 0)
            begin
                x = y;
                z += (64'sd1 << 23);
            end
            else
            begin
                x = -y;
                z -= (64'sd1 << 23);
            end
            y = 0;
        end
        x *= 65536;
        y *= 65536;
        for (int k = 0; k < STAGES; k++)
        begin
            xs = floor_shift(x, k);
            ys = floor_shift(y, k);
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z += longint'(atan_lut(k));
            end
            else if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                z -= longint'(atan_lut(k));
            end
        end
        q = (z >= 0) ? (z >>> 16) : -((-z) >>> 16);
        return q[7:0];
    endfunction

    function automatic logic [7:0] tunnel_depth(longint i, longint j, longint h);
        longint s, lim, v, c;
        s = i * i + j * j + h * h;
        lim = 65536 * h * h;
        v = 0;
        for (int b = 8; b >= 0; b--)
        begin
            c = v | (64'sd1 << b);
            if (c <= 256 && c * c * s <= lim)
                v = c;
        end
        return v[7:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // Track registers, queue predictions, check result beats
    always @(posedge clk or negedge rst_n)
    begin
        longint ci, cj, c11;
        coord_t e;
        if (!rst_n)
        begin
            width_reg = 640;
            height_reg = 480;
            scroll_u_reg = 0;
            scroll_v_reg = 0;
            coord_queue.delete();
            fail_count = 0;
            result_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                ci = longint'(pixel_x) - (width_reg >> 1);
                cj = longint'(pixel_y) - (height_reg >> 1);
                e.u = tunnel_angle(ci, -cj) + scroll_u_reg;
                e.v = tunnel_depth(ci, cj, height_reg) + scroll_v_reg;
                coord_queue.push_back(e);
            end
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (coord_queue.size() == 0)
                    report_mismatch("unexpected beat", 1, 0);
                else
                begin
                    e = coord_queue.pop_front();
                    if (tex_u !== e.u) report_mismatch("tex_u", tex_u, e.u);
                    if (tex_v !== e.v) report_mismatch("tex_v", tex_v, e.v);
                end
            end
            if (cfg_write)
            begin
                c11 = longint'(cfg_data);
                case (cfg_index)
                    REG_SCREEN_WIDTH:  width_reg = (c11 > 1024) ? 1024 : c11;
                    REG_SCREEN_HEIGHT: height_reg = (c11 > 1024) ? 1024 : c11;
                    REG_SCROLL_U:      scroll_u_reg = cfg_data[7:0];
                    REG_SCROLL_V:      scroll_v_reg = cfg_data[7:0];
                    default: ;
                endcase
            end
            pending_count = coord_queue.size();
        end
    end
endmodule

// ===== tb/tb_tunnel_texture_coordinate_generator.sv =====
// Top of the tunnel texture coordinate generator testbench: drives config,
// pixels and output stall, and gives the verdict. Uses ttcg_pkg and the checker.
module tb_tunnel_texture_coordinate_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import ttcg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [7:0] REG_UNUSED = 8'd7;  // index past the register list

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_write = 0;
    logic [7:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic [PIX_W-1:0] pixel_x = '0;
    logic [PIX_W-1:0] pixel_y = '0;
    logic out_valid;
    logic out_stall = 0;
    logic [7:0] tex_u, tex_v;
    int fail_count, pending_count, result_count;
    int send_idle_pct = 0, recv_idle_pct = 0;
    bit hold_off = 0;
    int idle_cycles = 0;
    int pixel_count = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    tunnel_texture_coordinate_generator u_dut (.*);

    tunnel_texture_coordinate_checker u_chk (.*);

    // Receiver stall, random or a long hold-off
    always @(posedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    // Watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("tunnel_texture_coordinate_generator test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [7:0] idx, input int val);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_write <= 0;
    endtask

    // Send one pixel beat, with random gaps ahead of it
    task automatic send_pixel(input int x, input int y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        pixel_x <= PIX_W'(x);
        pixel_y <= PIX_W'(y);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixel_count++;
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic random_pixels(input int n, input int w, input int h);
        for (int k = 0; k < n; k++)
            if ($urandom_range(3) == 0)
                send_pixel($urandom_range(1023), $urandom_range(1023));
            else
                send_pixel($urandom_range(w - 1), $urandom_range(h - 1));
    endtask

    task automatic random_config(output int w, output int h);
        w = $urandom_range(2, 1024);
        h = $urandom_range(2, 1024);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_SCROLL_U, $urandom_range(255));
        write_reg(REG_SCROLL_V, $urandom_range(255));
    endtask

    initial
    begin
        int w, h;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: centre, axes, corners at reset setting
        send_idle_pct = 19;
        recv_idle_pct = 51;
        send_pixel(320, 240);
        send_pixel(0, 240);
        send_pixel(639, 240);
        send_pixel(320, 0);
        send_pixel(320, 479);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(1023, 0);
        send_pixel(0, 1023);
        drain();
        // Odd sizes, oversize saturation, extreme scroll
        write_reg(REG_SCREEN_WIDTH, 2047);
        write_reg(REG_SCREEN_HEIGHT, 1025);
        write_reg(REG_SCROLL_U, 255);
        write_reg(REG_SCROLL_V, 255);
        write_reg(REG_UNUSED, 5);
        send_pixel(512, 512);
        send_pixel(0, 512);
        send_pixel(1023, 1023);
        send_pixel(0, 0);
        drain();
        write_reg(REG_SCREEN_WIDTH, 3);
        write_reg(REG_SCREEN_HEIGHT, 0);
        write_reg(REG_SCROLL_U, 0);
        send_pixel(1, 0);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        drain();
        write_reg(REG_SCREEN_WIDTH, 2);
        write_reg(REG_SCREEN_HEIGHT, 2);
        write_reg(REG_SCROLL_V, 0);
        send_pixel(1, 1);
        send_pixel(0, 1);
        send_pixel(1, 0);
        send_pixel(682, 341);
        send_pixel(341, 682);
        drain();

        // Random phases with changing idle profiles
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase < 2)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 51;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_config(w, h);
            random_pixels(80, w, h);
            drain();
        end

        // Long receiver hold-off while pixels keep coming
        fork
            begin
                hold_off = 1;
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            random_pixels(40, w, h);
        join
        drain();

        $display("covered %0d pixels and %0d result beats over several screen settings",
                 pixel_count, result_count);
        if (fail_count == 0)
            $display("tunnel_texture_coordinate_generator test passed");
        else
            $display("tunnel_texture_coordinate_generator test failed");
        $finish;
    end
endmodule
